@@ rtl/best_rational_under_denominator_limit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for best_rational_under_denominator_limit
// Concurrent property wrappers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEST_RATIONAL_UNDER_DENOMINATOR_LIMIT_ASSERT_SVH
`define BEST_RATIONAL_UNDER_DENOMINATOR_LIMIT_ASSERT_SVH

// same-cycle implication
`define BRUD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRUD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/brud_pkg.sv @@
// ----------------------------------------------------------------------------
// brud_pkg
// Shared constants and types for the best rational approximation block.
// ----------------------------------------------------------------------------
package brud_pkg;

  localparam int WORD_WIDTH_DEF = 32;   // internal arithmetic width
  localparam int FIELD_W        = 32;   // width of every port field
  localparam int CFG_W          = 32;   // width of the limit register

  localparam logic [CFG_W-1:0] MAX_DEN_RESET = CFG_W'(1001);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/best_rational_under_denominator_limit.sv @@
// ----------------------------------------------------------------------------
// best_rational_under_denominator_limit
// Continued-fraction expansion of numerator/denominator with best
// semiconvergent selection under a programmable denominator limit.
// ----------------------------------------------------------------------------
//  channel  direction  payload (low bits first)
//  in_      slave      numerator[31:0], denominator[63:32]
//  out_     master     approx_numerator[31:0], approx_denominator[63:32]
//  cfg_     write      max_denominator[31:0]
//
//  Each continued-fraction term runs the shared radix-2 divider and then the
//  shared multiplier steps that form the next convergent.
//  A zero denominator skips the divider. in_tready is high only while idle;
//  a finished result waits in the output register and stalls the sequencer
//  only when a second result is ready before the first is taken.
//  Reset is synchronous, active low; the limit register resets to 1001.
// ----------------------------------------------------------------------------
module best_rational_under_denominator_limit import brud_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*FIELD_W-1:0] in_tdata,    // numerator, denominator
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*FIELD_W-1:0] out_tdata,   // approx_numerator, approx_denominator
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata    // max_denominator
);

  localparam int W = WORD_WIDTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_MULP  = 4'd2;
  localparam logic [3:0] S_ADDP  = 4'd3;
  localparam logic [3:0] S_ADDQ  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_DIVB  = 4'd7;
  localparam logic [3:0] S_MULA  = 4'd8;
  localparam logic [3:0] S_MULB  = 4'd9;
  localparam logic [3:0] S_CMP   = 4'd10;
  localparam logic [3:0] S_SMULP = 4'd11;
  localparam logic [3:0] S_SADDP = 4'd12;
  localparam logic [3:0] S_SADDQ = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic             first_r, first_nxt;

  logic [W-1:0] pa_r, pa_nxt, pb_r, pb_nxt, pc_r, pc_nxt;
  logic [W-1:0] qa_r, qa_nxt, qb_r, qb_nxt, qc_r, qc_nxt;
  logic [W-1:0] y_r, y_nxt, a_r, a_nxt, rem_r, rem_nxt, best_r, best_nxt;
  logic [W-1:0] lim_r, lim_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic [2*W-1:0] mul_r, mul_nxt, hold_r, hold_nxt;
  logic [FIELD_W-1:0] out_num_r, out_num_nxt, out_den_r, out_den_nxt;

  logic [W-1:0] in_x, in_y, cfg_lim, lowest;
  logic [W-1:0] mul_opa, mul_opb;
  logic         low_ok;

  logic         div_start;
  logic [W-1:0] div_dividend, div_divisor, div_quo, div_rem;
  div_stat_t    div_stat;

  brud_div #(.WORD_WIDTH(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign in_x    = in_tdata[W-1:0];
  assign in_y    = in_tdata[FIELD_W +: W];
  assign cfg_lim = (cfg_r[W-1:0] == '0) ? W'(1) : cfg_r[W-1:0];

  // half-quotient admissibility: a even and qa*prev_rem > rem*qb lowers the bound
  assign low_ok = ~a_r[0] && (hold_r > mul_r);
  assign lowest = (a_r >> 1) + (low_ok ? W'(0) : W'(1));

  always_comb begin
    case (state_r)
      S_MULP:  begin mul_opa = pb_r;  mul_opb = a_r;    end
      S_ADDP:  begin mul_opa = qb_r;  mul_opb = a_r;    end
      S_MULA:  begin mul_opa = qa_r;  mul_opb = y_r;    end
      S_MULB:  begin mul_opa = rem_r; mul_opb = qb_r;   end
      S_SMULP: begin mul_opa = pb_r;  mul_opb = best_r; end
      S_SADDP: begin mul_opa = qb_r;  mul_opb = best_r; end
      default: begin mul_opa = '0;    mul_opb = '0;     end
    endcase
    mul_nxt = (2*W)'(mul_opa) * (2*W)'(mul_opb);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    first_nxt     = first_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  pc_nxt = pc_r;
    qa_nxt = qa_r;  qb_nxt = qb_r;  qc_nxt = qc_r;
    y_nxt  = y_r;   a_nxt  = a_r;   rem_nxt = rem_r;
    best_nxt = best_r;
    lim_nxt  = lim_r;
    rn_nxt   = rn_r;
    rd_nxt   = rd_r;
    hold_nxt = hold_r;
    out_num_nxt = out_num_r;
    out_den_nxt = out_den_r;
    div_start    = 1'b0;
    div_dividend = in_x;
    div_divisor  = in_y;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          lim_nxt   = cfg_lim;
          y_nxt     = in_y;
          pa_nxt    = '0;
          pb_nxt    = W'(1);
          qa_nxt    = W'(1);
          qb_nxt    = '0;
          first_nxt = 1'b1;
          if (in_y == '0) begin
            // infinite ratio saturates
            rn_nxt    = '1;
            rd_nxt    = W'(1);
            state_nxt = S_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          a_nxt     = div_quo;
          rem_nxt   = div_rem;
          state_nxt = S_MULP;
        end
      end
      S_MULP: state_nxt = S_ADDP;
      S_ADDP: begin
        pc_nxt    = pa_r + mul_r[W-1:0];
        state_nxt = S_ADDQ;
      end
      S_ADDQ: begin
        qc_nxt    = qa_r + mul_r[W-1:0];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (rem_r == '0 || (!first_r && qc_r >= lim_r)) begin
          state_nxt = S_FIN;
        end else begin
          first_nxt    = 1'b0;
          pa_nxt       = pb_r;
          pb_nxt       = pc_r;
          qa_nxt       = qb_r;
          qb_nxt       = qc_r;
          y_nxt        = rem_r;
          div_start    = 1'b1;
          div_dividend = y_r;
          div_divisor  = rem_r;
          state_nxt    = S_DIV;
        end
      end
      S_FIN: begin
        if (qc_r <= lim_r) begin
          rn_nxt    = pc_r;
          rd_nxt    = qc_r;
          state_nxt = S_DONE;
        end else begin
          div_start    = 1'b1;
          div_dividend = lim_r - qa_r;
          div_divisor  = qb_r;
          state_nxt    = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_stat.done) begin
          best_nxt  = div_quo;
          state_nxt = S_MULA;
        end
      end
      S_MULA: state_nxt = S_MULB;
      S_MULB: begin
        hold_nxt  = mul_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (best_r < lowest) begin
          rn_nxt    = pb_r;
          rd_nxt    = qb_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SMULP;
        end
      end
      S_SMULP: state_nxt = S_SADDP;
      S_SADDP: begin
        rn_nxt    = pa_r + mul_r[W-1:0];
        state_nxt = S_SADDQ;
      end
      S_SADDQ: begin
        rd_nxt    = qa_r + mul_r[W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_num_nxt   = FIELD_W'(rn_r);
          out_den_nxt   = FIELD_W'(rd_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      cfg_r       <= MAX_DEN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;  pb_r <= pb_nxt;  pc_r <= pc_nxt;
    qa_r <= qa_nxt;  qb_r <= qb_nxt;  qc_r <= qc_nxt;
    y_r  <= y_nxt;   a_r  <= a_nxt;   rem_r <= rem_nxt;
    best_r    <= best_nxt;
    lim_r     <= lim_nxt;
    rn_r      <= rn_nxt;
    rd_r      <= rd_nxt;
    mul_r     <= mul_nxt;
    hold_r    <= hold_nxt;
    out_num_r <= out_num_nxt;
    out_den_r <= out_den_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_den_r, out_num_r};

`include "best_rational_under_denominator_limit_assert.svh"

  `BRUD_ASSERT_IMP(a_div_idle_start, div_start, !div_stat.busy, "divider restarted while busy")
  `BRUD_ASSERT_NXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != S_IDLE, "accepted transaction did not start")
  `BRUD_ASSERT_IMP(a_den_in_limit, out_tvalid, out_den_r <= FIELD_W'(lim_r) && out_den_r != '0, "result denominator outside limit")

endmodule

@@ rtl/brud_div.sv @@
// ----------------------------------------------------------------------------
// brud_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brud_div import brud_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] dividend,
  input  logic [WORD_WIDTH-1:0] divisor,
  output logic [WORD_WIDTH-1:0] quotient,
  output logic [WORD_WIDTH-1:0] remainder,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(WORD_WIDTH);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [WORD_WIDTH-1:0] quo_r, quo_nxt;
  logic [WORD_WIDTH-1:0] rem_r, rem_nxt;
  logic [WORD_WIDTH-1:0] dvs_r, dvs_nxt;
  logic [WORD_WIDTH:0]   part;
  logic [WORD_WIDTH:0]   diff;

  always_comb begin
    part     = {rem_r, quo_r[WORD_WIDTH-1]};
    diff     = part - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WORD_WIDTH - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // top bit of diff is the borrow: clear means the divisor fits
      if (!diff[WORD_WIDTH]) begin
        rem_nxt = diff[WORD_WIDTH-1:0];
      end else begin
        rem_nxt = part[WORD_WIDTH-1:0];
      end
      quo_nxt = {quo_r[WORD_WIDTH-2:0], ~diff[WORD_WIDTH]};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
